/* src/inv_pkg.sv */
// ----------------------------------------------------------------------------
// inv_pkg
// Types, constants and helper functions for the identity number validator.
// ----------------------------------------------------------------------------
package inv_pkg;

  localparam int unsigned LINE_LEN     = 11;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned VAL_W        = 7;
  localparam int unsigned HYPHEN_POS   = 6;
  localparam int unsigned CHECK_POS    = 10;
  localparam logic [7:0]  ASCII_ZERO   = 8'd48;
  localparam logic [7:0]  ASCII_NINE   = 8'd57;
  localparam logic [7:0]  ASCII_HYPHEN = 8'd45;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_beat_t;

  typedef struct packed {
    logic number_valid;
  } out_beat_t;

  // days in a month, month given as 1..12
  function automatic val_t month_len(input val_t month);
    val_t len;
    unique case (month)
      7'd2:                         len = 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:      len = 7'd30;
      default:                      len = 7'd31;
    endcase
    return len;
  endfunction

  // remainder by ten of a luhn sum (at most 81)
  function automatic logic [3:0] sum_mod10(input val_t sum);
    logic [3:0] r;
    priority if (sum >= 7'd80) r = 4'(sum - 7'd80);
    else if (sum >= 7'd70)     r = 4'(sum - 7'd70);
    else if (sum >= 7'd60)     r = 4'(sum - 7'd60);
    else if (sum >= 7'd50)     r = 4'(sum - 7'd50);
    else if (sum >= 7'd40)     r = 4'(sum - 7'd40);
    else if (sum >= 7'd30)     r = 4'(sum - 7'd30);
    else if (sum >= 7'd20)     r = 4'(sum - 7'd20);
    else if (sum >= 7'd10)     r = 4'(sum - 7'd10);
    else                       r = 4'(sum);
    return r;
  endfunction

  // ten-based value accumulation: acc*10 + d
  function automatic val_t acc10(input val_t acc, input logic [3:0] d);
    return 7'(({acc, 3'b000}) + ({acc, 1'b0}) + {3'b000, d});
  endfunction

endpackage

/* src/inv_if.sv */
// ----------------------------------------------------------------------------
// inv_in_if / inv_out_if
// Valid/ready channels for the character stream and the result stream.
// ----------------------------------------------------------------------------
interface inv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_line;

  modport source (output valid, output char_code, output end_of_line, input ready);
  modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

interface inv_out_if;
  logic valid;
  logic ready;
  logic number_valid;

  modport source (output valid, output number_valid, input ready);
  modport sink   (input valid, input number_valid, output ready);
endinterface

/* src/identity_number_validator.sv */
// ----------------------------------------------------------------------------
// identity_number_validator
// Checks a "YYMMDD-nnnC" personal identity number streamed one character
// per beat: format, calendar date and luhn check digit.
// ----------------------------------------------------------------------------
// Takes one character per clock cycle. Each accepted beat lands in an input
// register; from there the per-character update (position, date fields, luhn
// sum, format flag) runs into the line state, and on the end-of-line beat the
// verdict is written to the result register, so a line's last character passes
// through the input register and then the result register to its verdict. The result
// register lets input continue while a verdict waits to be taken; only an
// end-of-line beat stalls, and only while the previous verdict is still held.
// Characters past the eleventh are ignored; shorter lines report invalid.
module identity_number_validator (
  input  logic           clk,
  input  logic           rst_n,
  inv_in_if.sink         in_chan,
  inv_out_if.source      out_chan
);

  // input register
  logic                 s1_valid_r, s1_valid_nxt;
  inv_pkg::in_beat_t    s1_beat_r;

  // line state
  inv_pkg::pos_t        pos_r, pos_nxt;
  logic                 ok_r, ok_nxt;
  inv_pkg::val_t        year_r, year_nxt;
  inv_pkg::val_t        month_r, month_nxt;
  inv_pkg::val_t        day_r, day_nxt;
  inv_pkg::val_t        sum_r, sum_nxt;
  logic                 chk_r, chk_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_bit_r, out_bit_nxt;

  logic                 s1_go;
  logic                 is_digit;
  logic [3:0]           digit;
  logic [4:0]           dbl;
  logic [3:0]           dbl_fold;
  logic [3:0]           rem;
  logic [3:0]           want;
  logic                 date_ok;
  inv_pkg::val_t        day_limit;
  logic                 verdict;

  assign s1_go = s1_valid_r & (~s1_beat_r.end_of_line | ~out_valid_r | out_chan.ready);
  assign in_chan.ready = ~s1_valid_r | s1_go;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.number_valid = out_bit_r;

  assign is_digit = (s1_beat_r.char_code >= inv_pkg::ASCII_ZERO) &&
                    (s1_beat_r.char_code <= inv_pkg::ASCII_NINE);
  assign digit    = 4'(s1_beat_r.char_code - inv_pkg::ASCII_ZERO);
  assign dbl      = {digit, 1'b0};
  assign dbl_fold = (dbl > 5'd9) ? 4'(dbl - 5'd9) : dbl[3:0];
  assign rem      = inv_pkg::sum_mod10(sum_r);
  assign want     = (rem == 4'd0) ? 4'd0 : 4'(4'd10 - rem);

  // per-character update of the line state
  always_comb begin
    pos_nxt   = pos_r;
    ok_nxt    = ok_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    sum_nxt   = sum_r;
    chk_nxt   = chk_r;
    if (s1_go && pos_r < inv_pkg::POS_W'(inv_pkg::LINE_LEN)) begin
      pos_nxt = 4'(pos_r + 4'd1);
      if (pos_r == inv_pkg::POS_W'(inv_pkg::HYPHEN_POS)) begin
        if (s1_beat_r.char_code != inv_pkg::ASCII_HYPHEN) begin
          ok_nxt = 1'b0;
        end
      end else if (!is_digit) begin
        ok_nxt = 1'b0;
      end else begin
        unique case (pos_r)
          4'd0, 4'd1: year_nxt  = inv_pkg::acc10(year_r, digit);
          4'd2, 4'd3: month_nxt = inv_pkg::acc10(month_r, digit);
          4'd4, 4'd5: day_nxt   = inv_pkg::acc10(day_r, digit);
          default: ;
        endcase
        unique case (pos_r)
          4'd0, 4'd2, 4'd4, 4'd7, 4'd9: sum_nxt = 7'(sum_r + {3'b000, dbl_fold});
          4'd1, 4'd3, 4'd5, 4'd8:       sum_nxt = 7'(sum_r + {3'b000, digit});
          4'd10:                        chk_nxt = (want == digit);
          default: ;
        endcase
      end
    end
  end

  // date check on the updated fields
  always_comb begin
    day_limit = inv_pkg::month_len(month_nxt);
    if (month_nxt == 7'd2 && year_nxt[1:0] == 2'b00) begin
      day_limit = 7'd29;
    end
    date_ok = (month_nxt >= 7'd1) && (month_nxt <= 7'd12) &&
              (day_nxt >= 7'd1) && (day_nxt <= day_limit);
  end

  assign verdict = ok_nxt & (pos_nxt == inv_pkg::POS_W'(inv_pkg::LINE_LEN)) & date_ok & chk_nxt;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_chan.valid && in_chan.ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    out_bit_nxt   = out_bit_r;
    if (s1_go && s1_beat_r.end_of_line) begin
      out_valid_nxt = 1'b1;
      out_bit_nxt   = verdict;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      ok_r        <= 1'b1;
      year_r      <= '0;
      month_r     <= '0;
      day_r       <= '0;
      sum_r       <= '0;
      chk_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_go && s1_beat_r.end_of_line) begin
        // line done, back to a fresh line
        pos_r   <= '0;
        ok_r    <= 1'b1;
        year_r  <= '0;
        month_r <= '0;
        day_r   <= '0;
        sum_r   <= '0;
        chk_r   <= 1'b0;
      end else begin
        pos_r   <= pos_nxt;
        ok_r    <= ok_nxt;
        year_r  <= year_nxt;
        month_r <= month_nxt;
        day_r   <= day_nxt;
        sum_r   <= sum_nxt;
        chk_r   <= chk_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_beat_r.char_code   <= in_chan.char_code;
      s1_beat_r.end_of_line <= in_chan.end_of_line;
    end
    out_bit_r <= out_bit_nxt;
  end

endmodule
